### hdl/ssg_pkg.sv
// Shared types, fixed constants and elaboration-time table builders for the
// synthetic spectrum generator. No dependencies.
`default_nettype none

package ssg_pkg;

  localparam int BIN_W    = 10;
  localparam int STEP_W   = 16;
  localparam int SEED_W   = 32;
  localparam int MAG_W    = 16;
  localparam int ANG_W    = 32;
  localparam int POS_W    = BIN_W + STEP_W;
  localparam int ACC_W    = 17;
  localparam int CFG_IDX_W = 4;

  localparam int MUL_A_W  = 32;
  localparam int MUL_B_W  = 24;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;

  // Table depths are powers of two; index widths follow from them.
  localparam int SINE_DEPTH  = 256;
  localparam int SINE_IDX_W  = $clog2(SINE_DEPTH);
  localparam int GAUSS_DEPTH = 256;
  localparam int GAUSS_IDX_W = $clog2(GAUSS_DEPTH);

  localparam logic [MAG_W-1:0]  MAG_ONE    = 16'd32768;
  localparam logic [10:0]       NOISE_BASE = 11'd1311;
  localparam logic [10:0]       NOISE_SPAN = 11'd1966;
  localparam logic [STEP_W-1:0] BIN_STEP_RST = 16'd256;
  localparam logic [SEED_W-1:0] SEED_RST     = 32'd1;

  localparam logic [CFG_IDX_W-1:0] REG_BIN_STEP   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_SEED = 4'd1;

  localparam logic [ANG_W-1:0] ANG_STEP [2] = '{32'd12304175, 32'd7519218};
  localparam logic [ANG_W-1:0] ANG_INIT [2] = '{32'd0, 32'd1162060954};
  localparam logic [15:0]      CEN_BASE [2] = '{16'd20972, 16'd44564};
  localparam logic [14:0]      CEN_EXC  [2] = '{15'd14418, 15'd10486};
  localparam logic [19:0]      INV2S2   [2] = '{20'd888889, 20'd320000};
  localparam logic [14:0]      HEIGHT   [2] = '{15'd31130, 15'd26214};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CEN0,
    ST_CEN1,
    ST_CEN2,
    ST_NOISE,
    ST_POS,
    ST_SQ,
    ST_ZK,
    ST_LUT,
    ST_INT,
    ST_BUMP
  } phase_t;

  typedef struct packed {
    phase_t phase;
    logic   carrier;
  } ctrl_t;

  typedef struct packed {
    logic accept;
    logic start;
    logic out_busy;
  } status_t;

  typedef struct packed {
    logic               en;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef logic [MAG_W-1:0] sine_tab_t  [SINE_DEPTH+1];
  typedef logic [MAG_W-1:0] gauss_tab_t [GAUSS_DEPTH+1];

  // Sign-magnitude Q30 product, truncating towards zero.
  function automatic longint mul30(longint a, longint b);
    logic neg;
    longint unsigned ua;
    longint unsigned ub;
    longint p;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? longint'(-a) : a;
    ub = (b < 0) ? longint'(-b) : b;
    p = longint'((ua * ub) >> 30);
    return neg ? -p : p;
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    longint t;
    longint t2;
    longint p;
    longint s;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      t  = (longint'(k) << 30) / SINE_DEPTH;
      t2 = mul30(t, t);
      p  = 172272;
      p  = -5026996 + mul30(p, t2);
      p  = 85569306 + mul30(p, t2);
      p  = -693598671 + mul30(p, t2);
      p  = 1686629713 + mul30(p, t2);
      s  = mul30(p, t);
      if (s < 0) s = 0;
      s = (s + 16384) >>> 15;
      tab[k] = (s > 32768) ? MAG_ONE : MAG_W'(s);
    end
    return tab;
  endfunction

  // exp(-z) in Q15 for z in Q30: series for the fraction, e^-1 per whole unit.
  function automatic logic [MAG_W-1:0] exp_neg_q15(logic [63:0] z30);
    logic [63:0] one;
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] p;
    one = 64'd1073741824;
    n = z30 >> 30;
    f = z30 & 64'h3FFF_FFFF;
    p = one;
    p = one - ((f * p) >> 30) / 64'd12;
    p = one - ((f * p) >> 30) / 64'd11;
    p = one - ((f * p) >> 30) / 64'd10;
    p = one - ((f * p) >> 30) / 64'd9;
    p = one - ((f * p) >> 30) / 64'd8;
    p = one - ((f * p) >> 30) / 64'd7;
    p = one - ((f * p) >> 30) / 64'd6;
    p = one - ((f * p) >> 30) / 64'd5;
    p = one - ((f * p) >> 30) / 64'd4;
    p = one - ((f * p) >> 30) / 64'd3;
    p = one - ((f * p) >> 30) / 64'd2;
    p = one - ((f * p) >> 30);
    for (int m = 0; m < 17; m++) begin
      if (64'(m) < n) p = (p * 64'd395007542) >> 30;
    end
    p = (p + 64'd16384) >> 15;
    return (p > 64'd32768) ? MAG_ONE : MAG_W'(p);
  endfunction

  function automatic gauss_tab_t build_gauss();
    gauss_tab_t tab;
    logic [63:0] z30;
    for (int k = 0; k <= GAUSS_DEPTH; k++) begin
      z30 = ((64'(k) * 64'd16) << 30) / GAUSS_DEPTH;
      tab[k] = exp_neg_q15(z30);
    end
    return tab;
  endfunction

  localparam sine_tab_t  SINE_TAB  = build_sine();
  localparam gauss_tab_t GAUSS_TAB = build_gauss();

endpackage

`default_nettype wire

### hdl/ssg_if.sv
// Channel interfaces for the spectrum generator: bin requests, bin results
// and register writes. Depends on ssg_pkg for field widths.
`default_nettype none

interface ssg_item_if;
  logic                           valid;
  logic                           ready;
  logic [ssg_pkg::BIN_W-1:0]      bin_index;
  logic                           frame_start;
  logic                           frame_end;

  modport source (output valid, bin_index, frame_start, frame_end, input ready);
  modport sink   (input valid, bin_index, frame_start, frame_end, output ready);
endinterface

interface ssg_result_if;
  logic                           valid;
  logic                           ready;
  logic [ssg_pkg::MAG_W-1:0]      magnitude;
  logic [ssg_pkg::MAG_W-1:0]      frame_peak;
  logic                           last;

  modport source (output valid, magnitude, frame_peak, last, input ready);
  modport sink   (input valid, magnitude, frame_peak, last, output ready);
endinterface

interface ssg_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ssg_pkg::CFG_IDX_W-1:0]  index;
  logic [ssg_pkg::SEED_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hdl/ssg_mul.sv
// Shared multiplier with a registered product, loaded only when requested.
// Depends on ssg_pkg.
`default_nettype none

module ssg_mul (
  input  wire logic                      clk,
  input  wire ssg_pkg::mul_req_t         req,
  output logic [ssg_pkg::PROD_W-1:0]     prod
);
  import ssg_pkg::*;

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod <= PROD_W'(req.a) * PROD_W'(req.b);
    end
  end

endmodule

`default_nettype wire

### hdl/ssg_ctrl.sv
// Sequencer for the spectrum generator: steps the shared multiplier through
// centre update, noise, position and the two Gaussian passes. Uses ssg_pkg.
`default_nettype none

module ssg_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ssg_pkg::status_t  status,
  output ssg_pkg::ctrl_t         ctl
);
  import ssg_pkg::*;

  phase_t state;
  phase_t state_next;
  logic   carrier;
  logic   carrier_next;
  logic   booting;
  logic   booting_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CEN0;   // centres for the reset angles
      carrier <= 1'b0;
      booting <= 1'b1;
    end else begin
      state   <= state_next;
      carrier <= carrier_next;
      booting <= booting_next;
    end
  end

  always_comb begin
    state_next   = state;
    carrier_next = carrier;
    booting_next = booting;
    case (state)
      ST_IDLE: begin
        if (status.accept) begin
          state_next = status.start ? ST_CEN0 : ST_NOISE;
        end
      end
      ST_CEN0:  state_next = ST_CEN1;
      ST_CEN1:  state_next = ST_CEN2;
      ST_CEN2: begin
        state_next   = booting ? ST_IDLE : ST_NOISE;
        booting_next = 1'b0;
      end
      ST_NOISE: state_next = ST_POS;
      ST_POS:   state_next = ST_SQ;
      ST_SQ:    state_next = ST_ZK;
      ST_ZK:    state_next = ST_LUT;
      ST_LUT:   state_next = ST_INT;
      ST_INT:   state_next = ST_BUMP;
      ST_BUMP: begin
        if (!carrier) begin
          state_next   = ST_SQ;
          carrier_next = 1'b1;
        end else if (!status.out_busy) begin
          state_next   = ST_IDLE;
          carrier_next = 1'b0;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  assign ctl.phase   = state;
  assign ctl.carrier = carrier;

endmodule

`default_nettype wire

### hdl/synthetic_spectrum_generator_core.sv
// Top level of the synthetic spectrum generator: register file, datapath and
// output register. Depends on ssg_pkg, ssg_if, ssg_mul and ssg_ctrl.
//
//   channel  | modport | transfer moves
//   ---------+---------+-------------------------------------------
//   item     | sink    | bin_index, frame_start, frame_end
//   result   | source  | magnitude, frame_peak, last
//   cfg      | sink    | index, data (always ready)
//
// A bin with frame_start set first runs the centre update; all steps are
// paced by the single shared multiplier, one product per cycle in the
// multiplying phases. After rst the block computes the carrier centres
// before item.ready rises. rst is synchronous, active high.
// A result waiting in the output register stalls only the final step of the
// next bin; the next item is accepted meanwhile.
`default_nettype none

module synthetic_spectrum_generator_core (
  input  wire logic      clk,
  input  wire logic      rst,
  ssg_item_if.sink       item,
  ssg_result_if.source   result,
  ssg_cfg_if.sink        cfg
);
  import ssg_pkg::*;

  ctrl_t    ctl;
  status_t  status;
  mul_req_t mreq;
  logic [PROD_W-1:0] prod;

  logic [STEP_W-1:0] bin_step;
  logic [SEED_W-1:0] noise_reg;
  logic [ANG_W-1:0]  angle [2];
  logic [15:0]       centre [2];
  logic [MAG_W-1:0]  peak;
  logic [BIN_W-1:0]  bin_r;
  logic              last_r;
  logic [POS_W-1:0]  pos;
  logic              gz;
  logic              sin_neg;
  logic [MAG_W-1:0]  a_reg;
  logic [ACC_W-1:0]  acc;
  logic [MAG_W-1:0]  out_mag;
  logic [MAG_W-1:0]  out_peak;
  logic              out_last;
  logic              out_valid;

  logic accept;
  logic out_busy;

  logic [SEED_W-1:0] x1;
  logic [SEED_W-1:0] x2;
  logic [SEED_W-1:0] x_next;

  logic [ANG_W-1:0]      sin_ang;
  logic [SINE_IDX_W-1:0] sin_i;
  logic [SINE_IDX_W:0]   sin_idx;
  logic [MAG_W-1:0]      sin_mag;
  logic [14:0]           cen_off;
  logic [15:0]           cen_new;
  logic                  cen_c;

  logic [POS_W-1:0]  pos_src;
  logic [POS_W:0]    d;
  logic [POS_W:0]    ad_full;
  logic              ad_over;
  logic [15:0]       ad;

  logic [31:0]            z20;
  logic                   z_over;
  logic [GAUSS_IDX_W-1:0] g_idx;
  logic [15:0]            g_fr;
  logic [MAG_W-1:0]       ga;
  logic [MAG_W-1:0]       gb;
  logic [MAG_W-1:0]       g_diff;
  logic [MAG_W-1:0]       g_val;

  logic [MAG_W-1:0]  bump;
  logic [ACC_W-1:0]  sum;
  logic [MAG_W-1:0]  value;
  logic [MAG_W-1:0]  peak_new;

  assign accept   = item.valid && item.ready;
  assign out_busy = out_valid && !result.ready;

  assign status.accept   = accept;
  assign status.start    = item.frame_start;
  assign status.out_busy = out_busy;

  ssg_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctl    (ctl)
  );

  ssg_mul u_mul (
    .clk  (clk),
    .req  (mreq),
    .prod (prod)
  );

  // xorshift32, shifts 13, 17, 5
  assign x1     = noise_reg ^ (noise_reg << 13);
  assign x2     = x1 ^ (x1 >> 17);
  assign x_next = x2 ^ (x2 << 5);

  // Quarter-wave sine lookup; odd quadrants mirror, upper half negates.
  assign sin_ang = (ctl.phase == ST_CEN1) ? angle[1] : angle[0];
  assign sin_i   = sin_ang[ANG_W-3 -: SINE_IDX_W];
  assign sin_idx = sin_ang[ANG_W-2] ? (SINE_IDX_W+1)'(SINE_DEPTH) - {1'b0, sin_i}
                                    : {1'b0, sin_i};
  assign sin_mag = SINE_TAB[sin_idx];

  // Centre from the excursion product; the result never leaves 16 bits.
  assign cen_c   = (ctl.phase == ST_CEN2);
  assign cen_off = 15'((prod[29:0] + 30'd16384) >> 15);
  assign cen_new = sin_neg ? CEN_BASE[cen_c] - {1'b0, cen_off}
                           : CEN_BASE[cen_c] + {1'b0, cen_off};

  // Distance to the carrier centre; the first pass takes the position
  // straight from the product register.
  assign pos_src = ctl.carrier ? pos : prod[POS_W-1:0];
  assign d       = {1'b0, pos_src} - (POS_W+1)'(centre[ctl.carrier]);
  assign ad_full = d[POS_W] ? -d : d;
  assign ad_over = |ad_full[POS_W:16];
  assign ad      = ad_full[15:0];

  // z in Q20; with a 256-entry table the index is z[23:16], fraction z[15:0].
  assign z20    = prod[51:20];
  assign z_over = |z20[31:24];
  assign g_idx  = z20[23 -: GAUSS_IDX_W];
  assign g_fr   = z20[15:0];
  assign ga     = GAUSS_TAB[g_idx];
  assign gb     = GAUSS_TAB[(GAUSS_IDX_W+1)'(g_idx) + 1'b1];
  assign g_diff = (ga > gb) ? ga - gb : '0;
  assign g_val  = gz ? '0 : a_reg - prod[31:16];

  assign bump     = MAG_W'((prod[30:0] + 31'd16384) >> 15);
  assign sum      = acc + ACC_W'(bump);
  assign value    = (sum > ACC_W'(MAG_ONE)) ? MAG_ONE : sum[MAG_W-1:0];
  assign peak_new = (value > peak) ? value : peak;

  always_comb begin
    mreq.en = 1'b0;
    mreq.a  = '0;
    mreq.b  = '0;
    case (ctl.phase)
      ST_CEN0, ST_CEN1: begin
        mreq.en = 1'b1;
        mreq.a  = MUL_A_W'(sin_mag);
        mreq.b  = MUL_B_W'(CEN_EXC[ctl.phase == ST_CEN1]);
      end
      ST_NOISE: begin
        mreq.en = 1'b1;
        mreq.a  = MUL_A_W'(x_next[23:0]);
        mreq.b  = MUL_B_W'(NOISE_SPAN);
      end
      ST_POS: begin
        mreq.en = 1'b1;
        mreq.a  = MUL_A_W'(bin_r);
        mreq.b  = MUL_B_W'(bin_step);
      end
      ST_SQ: begin
        mreq.en = 1'b1;
        mreq.a  = MUL_A_W'(ad);
        mreq.b  = MUL_B_W'(ad);
      end
      ST_ZK: begin
        mreq.en = 1'b1;
        mreq.a  = prod[31:0];
        mreq.b  = MUL_B_W'(INV2S2[ctl.carrier]);
      end
      ST_LUT: begin
        mreq.en = 1'b1;
        mreq.a  = MUL_A_W'(g_diff);
        mreq.b  = MUL_B_W'(g_fr);
      end
      ST_INT: begin
        mreq.en = 1'b1;
        mreq.a  = MUL_A_W'(g_val);
        mreq.b  = MUL_B_W'(HEIGHT[ctl.carrier]);
      end
      default: begin
        mreq.en = 1'b0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_step  <= BIN_STEP_RST;
      noise_reg <= SEED_RST;
      angle[0]  <= ANG_INIT[0];
      angle[1]  <= ANG_INIT[1];
      peak      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.phase == ST_BUMP && ctl.carrier && !out_busy) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      if (accept && item.frame_start) begin
        angle[0] <= angle[0] + ANG_STEP[0];
        angle[1] <= angle[1] + ANG_STEP[1];
        peak     <= '0;
      end
      if (ctl.phase == ST_BUMP && ctl.carrier && !out_busy) begin
        peak <= peak_new;
      end
      // a seed write takes precedence over the generator step
      if (cfg.valid && cfg.index == REG_NOISE_SEED) begin
        noise_reg <= (cfg.data == '0) ? SEED_RST : cfg.data;
      end else if (ctl.phase == ST_NOISE) begin
        noise_reg <= x_next;
      end
      if (cfg.valid && cfg.index == REG_BIN_STEP) begin
        bin_step <= cfg.data[STEP_W-1:0];
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      bin_r  <= item.bin_index;
      last_r <= item.frame_end;
    end
    case (ctl.phase)
      ST_CEN0: sin_neg <= sin_ang[ANG_W-1];
      ST_CEN1: begin
        centre[0] <= cen_new;
        sin_neg   <= sin_ang[ANG_W-1];
      end
      ST_CEN2: centre[1] <= cen_new;
      ST_POS:  acc <= ACC_W'(NOISE_BASE) + ACC_W'(prod[34:24]);
      ST_SQ: begin
        pos <= pos_src;
        gz  <= ad_over;
      end
      ST_LUT: begin
        a_reg <= ga;
        gz    <= gz | z_over;
      end
      ST_BUMP: begin
        if (!ctl.carrier) begin
          acc <= sum;
        end else if (!out_busy) begin
          out_mag  <= value;
          out_peak <= peak_new;
          out_last <= last_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign item.ready        = (ctl.phase == ST_IDLE);
  assign cfg.ready         = 1'b1;
  assign result.valid      = out_valid;
  assign result.magnitude  = out_mag;
  assign result.frame_peak = out_peak;
  assign result.last       = out_last;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> ctl.phase != ST_IDLE)
    else $error("accepted item did not start the sequence");

  a_peak_covers_bin: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.frame_peak >= result.magnitude)
    else $error("frame peak below bin magnitude");

  a_mag_saturated: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.magnitude <= MAG_ONE)
    else $error("magnitude above full scale");

  a_second_carrier: assert property (@(posedge clk) disable iff (rst)
    (ctl.phase == ST_BUMP && !ctl.carrier) |=> (ctl.phase == ST_SQ && ctl.carrier))
    else $error("second carrier pass skipped");

endmodule

`default_nettype wire

### verif/synthetic_spectrum_generator_core_test.sv
// Self-checking bench for synthetic_spectrum_generator_core: random bin requests
// scored against an in-bench fixed-point predictor of noise floor, drifting bumps and peak.
// Depends on ssg_pkg (register indexes, widths) and the channel interfaces in ssg_if.
`default_nettype none

module synthetic_spectrum_generator_core_test;

  localparam int CLK_PERIOD     = 8;
  localparam int TIMEOUT_CYCLES = 1_500_000;
  localparam int ITEMS_PER_PASS = 175;
  localparam int BIN_TOP        = (1 << ssg_pkg::BIN_W) - 1;

  localparam logic [ssg_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = ssg_pkg::REG_NOISE_SEED + 1'b1;
  localparam logic [ssg_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = '1;

  // Predictor constants, Q1.15 magnitudes and Q0.16 positions.
  localparam int          TAB_DEPTH     = 256;
  localparam logic [15:0] STEP_AT_RESET = 16'd256;
  localparam logic [31:0] DRIFT_STEP  [2] = '{32'd12304175, 32'd7519218};
  localparam logic [31:0] START_PHASE [2] = '{32'd0, 32'd1162060954};
  localparam int          CENTRE_BASE [2] = '{20972, 44564};
  localparam int          CENTRE_SWING[2] = '{14418, 10486};
  localparam longint unsigned SPREAD_K [2] = '{64'd888889, 64'd320000};
  localparam int unsigned PEAK_HEIGHT [2] = '{31130, 26214};
  localparam int unsigned FULL_SCALE    = 32768;
  localparam int unsigned NOISE_FLOOR   = 1311;
  localparam int unsigned NOISE_RANGE   = 1966;
  localparam longint unsigned Q30_UNIT  = 64'd1073741824;
  localparam longint unsigned E_RECIP   = 64'd395007542;

  typedef struct packed {
    logic [15:0] magnitude;
    logic [15:0] frame_peak;
    logic        last;
  } bin_result_t;

  class spectrum_scoreboard;
    logic [15:0] sine_tab [TAB_DEPTH+1];
    logic [15:0] exp_tab  [TAB_DEPTH+1];
    logic [15:0] step_q16;
    logic [31:0] noise_state;
    logic [31:0] angle [2];
    logic [15:0] centre [2];
    logic [15:0] peak_so_far;
    bin_result_t awaited [$];
    int errors;
    int bins_checked;
    int frames_started;
    int reg_writes;

    function new();
      build_tables();
      step_q16 = STEP_AT_RESET;
      noise_state = 32'd1;
      angle[0] = START_PHASE[0];
      angle[1] = START_PHASE[1];
      move_centres();
      peak_so_far = '0;
      errors = 0;
      bins_checked = 0;
      frames_started = 0;
      reg_writes = 0;
    endfunction

    // Sign-magnitude Q30 product, truncated towards zero.
    function longint q30_mul(longint a, longint b);
      longint unsigned ma;
      longint unsigned mb;
      longint unsigned pr;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      pr = (ma * mb) >> 30;
      return ((a < 0) != (b < 0)) ? -longint'(pr) : longint'(pr);
    endfunction

    function void build_tables();
      longint t;
      longint t2;
      longint p;
      longint s;
      longint unsigned z;
      longint unsigned whole;
      longint unsigned frac;
      longint unsigned e;
      for (int k = 0; k <= TAB_DEPTH; k++) begin
        // quarter-wave sine from a degree-9 odd polynomial
        t  = (longint'(k) << 30) / TAB_DEPTH;
        t2 = q30_mul(t, t);
        p  = 172272;
        p  = -5026996 + q30_mul(p, t2);
        p  = 85569306 + q30_mul(p, t2);
        p  = -693598671 + q30_mul(p, t2);
        p  = 1686629713 + q30_mul(p, t2);
        s  = q30_mul(p, t);
        if (s < 0) s = 0;
        s = (s + 16384) >>> 15;
        sine_tab[k] = (s > FULL_SCALE) ? 16'(FULL_SCALE) : 16'(s);
        // exp(-z) over z in [0, 16]
        z = ((64'(k) * 64'd16) << 30) / TAB_DEPTH;
        whole = z >> 30;
        frac = z & 64'h3FFF_FFFF;
        e = Q30_UNIT;
        for (int j = 12; j >= 1; j--) begin
          e = Q30_UNIT - ((frac * e) >> 30) / 64'(j);
        end
        while (whole > 0) begin
          e = (e * E_RECIP) >> 30;
          whole--;
        end
        e = (e + 64'd16384) >> 15;
        exp_tab[k] = (e > FULL_SCALE) ? 16'(FULL_SCALE) : 16'(e);
      end
    endfunction

    function int sine_at(logic [31:0] a);
      int i;
      int v;
      i = int'((64'(a[29:0]) * TAB_DEPTH) >> 30);
      if (i > TAB_DEPTH) i = TAB_DEPTH;
      if (a[30]) i = TAB_DEPTH - i;
      v = int'(sine_tab[i]);
      return a[31] ? -v : v;
    endfunction

    function void move_centres();
      int s;
      int mag;
      int off;
      int v;
      for (int c = 0; c < 2; c++) begin
        s = sine_at(angle[c]);
        mag = (s < 0) ? -s : s;
        off = (CENTRE_SWING[c] * mag + 16384) >>> 15;
        v = (s < 0) ? CENTRE_BASE[c] - off : CENTRE_BASE[c] + off;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        centre[c] = 16'(v);
      end
    endfunction

    // Gaussian shape at a position, Q1.15, with linear table interpolation
    function int unsigned bump_shape(longint unsigned pos, int c);
      longint unsigned d;
      longint unsigned z;
      longint unsigned sc;
      longint unsigned idx;
      longint unsigned fr;
      longint unsigned a;
      longint unsigned b;
      longint unsigned diff;
      d = (pos >= 64'(centre[c])) ? pos - 64'(centre[c]) : 64'(centre[c]) - pos;
      if (d >= 64'd65536) return 0;
      z = (d * d * SPREAD_K[c]) >> 20;
      if (z >= (64'd16 << 20)) return 0;
      sc = z * TAB_DEPTH;
      idx = sc >> 24;
      if (idx >= TAB_DEPTH) return 0;
      fr = (sc >> 8) & 64'hFFFF;
      a = 64'(exp_tab[idx]);
      b = 64'(exp_tab[idx + 1]);
      diff = (a > b) ? a - b : 0;
      return 32'(a - ((diff * fr) >> 16));
    endfunction

    function void predict_bin(logic [9:0] bin, logic start, logic fin);
      bin_result_t r;
      longint unsigned pos;
      int unsigned value;
      logic [31:0] x;
      pos = 64'(bin) * 64'(step_q16);
      if (start) begin
        angle[0] += DRIFT_STEP[0];
        angle[1] += DRIFT_STEP[1];
        move_centres();
        peak_so_far = '0;
        frames_started++;
      end
      x = noise_state;
      x ^= x << 13;
      x ^= x >> 17;
      x ^= x << 5;
      noise_state = x;
      value = NOISE_FLOOR + 32'((64'(NOISE_RANGE) * 64'(x[23:0])) >> 24);
      for (int c = 0; c < 2; c++) begin
        value += (PEAK_HEIGHT[c] * bump_shape(pos, c) + 32'd16384) >> 15;
      end
      if (value > FULL_SCALE) value = FULL_SCALE;
      if (value > peak_so_far) peak_so_far = value[15:0];
      r.magnitude = value[15:0];
      r.frame_peak = peak_so_far;
      r.last = fin;
      awaited.push_back(r);
    endfunction

    function void write_register(logic [ssg_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
      reg_writes++;
      case (idx)
        ssg_pkg::REG_BIN_STEP: begin
          step_q16 = data[15:0];
        end
        ssg_pkg::REG_NOISE_SEED: begin
          noise_state = (data == '0) ? 32'd1 : data;
        end
        default: ;
      endcase
    endfunction

    function void compare_bin(logic [15:0] mag, logic [15:0] peak, logic fin);
      bin_result_t want;
      if (awaited.size() == 0) begin
        $error("result transfer with no request pending: magnitude %0d, frame_peak %0d",
               mag, peak);
        errors++;
        return;
      end
      want = awaited.pop_front();
      bins_checked++;
      if (mag !== want.magnitude) begin
        $error("magnitude: expected %0d, got %0d", want.magnitude, mag);
        errors++;
      end
      if (peak !== want.frame_peak) begin
        $error("frame_peak: expected %0d, got %0d", want.frame_peak, peak);
        errors++;
      end
      if (fin !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, fin);
        errors++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic source_steady = 1'b0;
  logic sink_steady = 1'b0;
  int   bins_sent = 0;
  spectrum_scoreboard sb;

  ssg_item_if   item_ch ();
  ssg_result_if result_ch ();
  ssg_cfg_if    cfg_ch ();

  synthetic_spectrum_generator_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(21, 80);
  endfunction

  // bin whose position lands near a carrier centre, for the current bin_step
  function automatic logic [9:0] bin_near(int c, int offset);
    int b;
    if (sb.step_q16 == 0) return '0;
    b = int'(sb.centre[c]) / int'(sb.step_q16) + offset;
    if (b < 0) b = 0;
    if (b > BIN_TOP) b = BIN_TOP;
    return 10'(b);
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.write_register(cfg_ch.index, cfg_ch.data);
      if (item_ch.valid && item_ch.ready)
        sb.predict_bin(item_ch.bin_index, item_ch.frame_start, item_ch.frame_end);
      if (result_ch.valid && result_ch.ready)
        sb.compare_bin(result_ch.magnitude, result_ch.frame_peak, result_ch.last);
    end
  end

  // result back-pressure
  initial begin
    int stall;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      result_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      stall = sink_steady ? 0 : pick_gap();
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Timed out with %0d bins still awaited", sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

  // valid is left high after a transfer unless a gap follows
  task automatic send_bin(logic [9:0] b, logic s, logic e);
    int gap;
    item_ch.valid <= 1'b1;
    item_ch.bin_index <= b;
    item_ch.frame_start <= s;
    item_ch.frame_end <= e;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    bins_sent++;
    gap = source_steady ? 0 : pick_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(logic [ssg_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // broken frames drop the start, drop the end, or carry a stray start mid-frame
  task automatic run_frame(int n, int span, bit broken);
    int flaw;
    logic [9:0] b;
    logic s;
    logic e;
    flaw = broken ? $urandom_range(2) : 3;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 30) b = bin_near($urandom_range(1), $urandom_range(6) - 3);
      else b = 10'((i * (span + 1)) / n);
      s = (i == 0 && flaw != 0) || (flaw == 2 && i == n / 2);
      e = (i == n - 1) && flaw != 1;
      send_bin(b, s, e);
    end
  endtask

  initial begin
    int target;
    int span;
    int sel;
    logic [15:0] pass_step [5];
    sb = new();
    item_ch.valid <= 1'b0;
    item_ch.bin_index <= '0;
    item_ch.frame_start <= 1'b0;
    item_ch.frame_end <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: both carriers, beyond-frame bin, single-bin frame
    send_bin(10'd0, 1'b1, 1'b0);
    send_bin(bin_near(0, 0), 1'b0, 1'b0);
    send_bin(bin_near(1, 0), 1'b0, 1'b0);
    send_bin(10'(BIN_TOP), 1'b0, 1'b1);
    send_bin(10'd512, 1'b1, 1'b1);
    // no frame_start: centres and peak carry on
    send_bin(10'd100, 1'b0, 1'b0);
    send_bin(10'd300, 1'b0, 1'b1);

    // zero seed, zero step: everything at position 0
    write_cfg(ssg_pkg::REG_NOISE_SEED, 32'd0);
    write_cfg(ssg_pkg::REG_BIN_STEP, 32'd0);
    send_bin(10'(BIN_TOP), 1'b1, 1'b0);
    send_bin(10'd0, 1'b0, 1'b1);

    // writes to unused indexes must leave the state alone
    write_cfg(REG_SPARE_LO, 32'hFFFF_FFFF);
    write_cfg(REG_SPARE_HI, $urandom());
    write_cfg(ssg_pkg::REG_BIN_STEP, 32'h0000_FFFF);
    write_cfg(ssg_pkg::REG_NOISE_SEED, 32'hFFFF_FFFF);
    send_bin(10'd0, 1'b1, 1'b0);
    send_bin(10'd1, 1'b0, 1'b0);
    send_bin(10'(BIN_TOP), 1'b0, 1'b1);

    write_cfg(ssg_pkg::REG_BIN_STEP, 32'd1);
    send_bin(10'(BIN_TOP), 1'b1, 1'b0);
    send_bin(10'd0, 1'b0, 1'b1);

    // fine step right on top of carrier 0: magnitude at or close to saturation
    write_cfg(ssg_pkg::REG_BIN_STEP, 32'd32);
    send_bin(bin_near(0, 0), 1'b1, 1'b0);
    send_bin(bin_near(0, -1), 1'b0, 1'b0);
    send_bin(bin_near(0, 1), 1'b0, 1'b0);
    send_bin(bin_near(1, 0), 1'b0, 1'b0);
    send_bin(10'd700, 1'b0, 1'b1);

    write_cfg(ssg_pkg::REG_BIN_STEP, 32'd32768);
    send_bin(10'd0, 1'b1, 1'b0);
    send_bin(10'd1, 1'b0, 1'b0);
    send_bin(10'd2, 1'b0, 1'b1);

    pass_step[0] = STEP_AT_RESET;
    pass_step[1] = 16'd64;
    pass_step[2] = 16'($urandom_range(1, 32768));
    pass_step[3] = 16'd1024;
    pass_step[4] = 16'd32768;
    for (int ph = 0; ph < 5; ph++) begin
      write_cfg(ssg_pkg::REG_BIN_STEP, 32'(pass_step[ph]));
      write_cfg(ssg_pkg::REG_NOISE_SEED, $urandom());
      if (ph == 2)
        write_cfg(ssg_pkg::CFG_IDX_W'($urandom_range(int'(REG_SPARE_LO), int'(REG_SPARE_HI))),
                  $urandom());
      source_steady = (ph == 1);
      sink_steady = (ph == 1);
      span = 65536 / int'(pass_step[ph]) + 2;
      if (span > BIN_TOP) span = BIN_TOP;
      target = bins_sent + ITEMS_PER_PASS;
      while (bins_sent < target) begin
        sel = $urandom_range(99);
        if (sel < 65) run_frame($urandom_range(2, 40), span, 1'b0);
        else if (sel < 80) run_frame($urandom_range(2, 40), span, 1'b1);
        else if (sel < 96) send_bin(10'($urandom_range(BIN_TOP)), 1'($urandom), 1'($urandom));
        else drain();
      end
    end
    source_steady = 1'b0;
    sink_steady = 1'b0;

    drain();
    repeat (40) @(posedge clk);
    $display("Checked %0d bins over %0d frame starts after %0d register writes;",
             sb.bins_checked, sb.frames_started, sb.reg_writes);
    $display("bin_step swept 0..65535, zero and all-ones seeds, broken frames, stalls.");
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
